// ===== sv/pwli_pkg.sv =====
// Shared types and constants of the piecewise linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package pwli_pkg;

    // Table size default and point count limits
    localparam int MAX_POINTS_DEF = 64;
    localparam int MIN_POINTS     = 2;

    // Field widths
    localparam int XY_W     = 16;
    localparam int IDX_W    = 6;
    localparam int PTS_W    = 7;
    localparam int DIFF_W   = XY_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int QUO_W    = 2 * XY_W;
    localparam int REM_W    = XY_W + 1;
    localparam int ENTRY_W  = 2 * XY_W;

    // Divider length, one quotient bit per step
    localparam int DIV_STEPS = QUO_W;

    // Input word layout, lowest field first
    localparam int IN_IDX_LO   = 0;
    localparam int IN_X_LO     = IN_IDX_LO + IDX_W;
    localparam int IN_Y_LO     = IN_X_LO + XY_W;
    localparam int IN_USED_W   = IN_Y_LO + XY_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = XY_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PTS_W;

    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESC   = 2'd1;

    localparam logic [PTS_W-1:0] POINTS_RST = 7'd2;

    // Item kinds carried on tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;       // latch query x
        logic last_load;   // latch last breakpoint and high-end test
        logic shift;       // current entry becomes previous entry
        logic pair_load;   // current entry is the upper bracket
        logic res_first;   // clamp to first y
        logic res_last;    // clamp to last y
        logic mul;         // form product and denominator
        logic div_init;    // load divider magnitudes
        logic div_step;    // one restoring division step
        logic res_interp;  // add signed quotient to lower y
        logic out_load;    // move result into output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;         // query x lies before the entry on the read port
        logic high;        // query x at or beyond the last breakpoint
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== sv/pwli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pwli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/pwli_ctrl.sv =====
// Controller: sequences the end checks, the breakpoint scan, the divide and the output.
`timescale 1ns / 1ps
`default_nettype none

module pwli_ctrl #(
    parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_query,
    output logic                            o_in_ready,
    input  wire logic [pwli_pkg::PTS_W-1:0] i_points,
    input  wire pwli_pkg::t_dp_sts          i_sts,
    output pwli_pkg::t_dp_cmd               o_cmd,
    output logic      [AW-1:0]              o_rd_addr,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready
);

    import pwli_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LAST  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DINIT = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_dp_cmd          w_cmd;

    logic [31:0]   w_pts, w_nlim, w_nlast_full;
    logic [AW-1:0] w_nlast;
    logic          w_acc_q;

    // Points in use, limited to between MIN_POINTS and the table size
    always_comb begin
        w_pts = 32'(i_points);
        if (w_pts < 32'(MIN_POINTS)) begin
            w_nlim = 32'(MIN_POINTS);
        end else if (w_pts > 32'(MAX_POINTS)) begin
            w_nlim = 32'(MAX_POINTS);
        end else begin
            w_nlim = w_pts;
        end
    end
    assign w_nlast_full = w_nlim - 32'd1;
    assign w_nlast      = w_nlast_full[AW-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc_q    = i_in_valid && o_in_ready && i_in_query;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_addr = w_nlast;
                if (w_acc_q) begin
                    w_cmd.start = 1'b1;
                    n_state     = S_LAST;
                end
            end
            S_LAST: begin
                w_cmd.last_load = 1'b1;
                n_addr          = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                if (r_addr == '0 && i_sts.hit) begin
                    w_cmd.res_first = 1'b1;
                    n_state         = S_OUT;
                end else if (r_addr == '0 && i_sts.high) begin
                    w_cmd.res_last = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.hit || r_addr == w_nlast) begin
                    w_cmd.pair_load = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    w_cmd.shift = 1'b1;
                    n_addr      = r_addr + 1'b1;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                w_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                w_cmd.res_interp = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // RAM is addressed with the next index so its data lines up with r_addr
    assign o_rd_addr   = n_addr;
    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    // A new output word only appears from the output state
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output word raised outside output state");

    // Divider setup always starts a full count
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DINIT) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("divider did not start at step zero");

    // Divider ends after its last step
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_LAST) |=> (r_state == S_FIN))
        else $error("divider overran its step count");

    // A free output slot takes the result and frees the input side
    a_out_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_out_ready))
        |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not handed to output register");

endmodule

`default_nettype wire

// ===== sv/pwli_dp.sv =====
// Datapath: end compares, bracket registers, multiplier, restoring divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module pwli_dp (
    input  wire logic                           i_clk,
    input  wire pwli_pkg::t_dp_cmd              i_cmd,
    output pwli_pkg::t_dp_sts                   o_sts,
    input  wire logic                           i_desc,
    input  wire logic signed [pwli_pkg::XY_W-1:0]    i_query_x,
    input  wire logic        [pwli_pkg::ENTRY_W-1:0] i_rd_data,
    output logic signed      [pwli_pkg::XY_W-1:0]    o_y_result,
    output logic                                     o_clamped
);

    import pwli_pkg::*;

    logic signed [XY_W-1:0]   r_x, r_ylast, r_xp, r_yp, r_xc, r_yc, r_res, r_out_y;
    logic                     r_high, r_res_clamp, r_out_clamp, r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIFF_W-1:0] r_den;
    logic        [QUO_W-1:0]  r_quo;
    logic        [REM_W-1:0]  r_rem;
    logic        [XY_W-1:0]   r_dmag;

    logic signed [XY_W-1:0]   w_xe, w_ye;
    logic                     w_hit, w_high;
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_den;
    logic signed [PROD_W-1:0] w_prod, w_pneg;
    logic signed [DIFF_W-1:0] w_dneg;
    logic        [REM_W-1:0]  w_shift;
    logic        [REM_W:0]    w_diff;
    logic        [QUO_W-1:0]  w_qs;

    // Entry on the read port
    assign w_xe = i_rd_data[XY_W-1:0];
    assign w_ye = i_rd_data[ENTRY_W-1:XY_W];

    // Position of query x against the entry
    assign w_hit  = i_desc ? (r_x > w_xe) : (r_x < w_xe);
    assign w_high = i_desc ? (r_x <= w_xe) : (r_x >= w_xe);

    assign o_sts.hit  = w_hit;
    assign o_sts.high = r_high;

    // Differences and product at full width
    assign w_dx   = DIFF_W'(r_x) - DIFF_W'(r_xp);
    assign w_dy   = DIFF_W'(r_yc) - DIFF_W'(r_yp);
    assign w_den  = DIFF_W'(r_xc) - DIFF_W'(r_xp);
    assign w_prod = w_dx * w_dy;

    // Magnitudes for the unsigned divider
    assign w_pneg = -r_prod;
    assign w_dneg = -r_den;

    // One restoring step
    assign w_shift = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dmag};

    // Quotient truncated toward zero
    assign w_qs = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_query_x;
        end
        if (i_cmd.last_load) begin
            r_ylast <= w_ye;
            r_high  <= w_high;
        end
        if (i_cmd.shift) begin
            r_xp <= w_xe;
            r_yp <= w_ye;
        end
        if (i_cmd.pair_load) begin
            r_xc <= w_xe;
            r_yc <= w_ye;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_den  <= w_den;
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_prod[PROD_W-1] ^ r_den[DIFF_W-1];
            r_quo  <= r_prod[PROD_W-1] ? w_pneg[QUO_W-1:0] : r_prod[QUO_W-1:0];
            r_dmag <= r_den[DIFF_W-1] ? w_dneg[XY_W-1:0] : r_den[XY_W-1:0];
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_diff[REM_W]) begin
                r_rem <= w_diff[REM_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        // Result select
        if (i_cmd.res_first) begin
            r_res       <= w_ye;
            r_res_clamp <= 1'b1;
        end else if (i_cmd.res_last) begin
            r_res       <= r_ylast;
            r_res_clamp <= 1'b1;
        end else if (i_cmd.res_interp) begin
            r_res       <= r_yp + signed'(w_qs[XY_W-1:0]);
            r_res_clamp <= 1'b0;
        end
        // Output word
        if (i_cmd.out_load) begin
            r_out_y     <= r_res;
            r_out_clamp <= r_res_clamp;
        end
    end

    assign o_y_result = r_out_y;
    assign o_clamped  = r_out_clamp;

endmodule

`default_nettype wire

// ===== sv/piecewise_linear_interpolator_unit.sv =====
// Piecewise linear interpolator: breakpoint table, scan, multiply and divide.
//
// Input stream: s_axis_tuser selects the word kind. A load word (tuser 0) writes
// one x/y breakpoint at point_index and gives no output word; an index at or
// beyond MAX_POINTS is dropped. A query word (tuser 1) gives one output word
// with the interpolated or clamped y and the clamp flag on tuser.
// Config channel: index 0 points in use (7 bits), index 1 descending order;
// always ready, write only while no query is in flight.
// A query first reads the last breakpoint, then scans the table from the first.
// A query before the first or at or beyond the last breakpoint is clamped and
// goes from the first entry to the output register; otherwise the scan runs to
// the upper bracket, then the product is formed, divided and added to lower y.
// The scan reads one breakpoint per cycle from the table RAM, and the radix-2
// divider resolves one of 32 quotient bits per cycle. Load words are taken
// back to back while no query is in flight. One query is worked on at a time;
// the input is ready again once the result sits in the output register, so a
// stalled receiver holds one word and stops the next query only at its
// hand-off. Reset clears the config to 2 points ascending and empties the output;
// table contents are kept and are only defined once written.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [5:0] point_index, [21:6] x_value, [37:22] y_value, [39:38] zero
    input  wire logic [pwli_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  wire logic                                s_axis_tuser,
    // Output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] y_result
    output logic      [pwli_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] clamped
    output logic                                     m_axis_tuser,
    // Config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pwli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pwli_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import pwli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic [PTS_W-1:0] r_points;
    logic             r_desc;

    logic [IDX_W-1:0]       w_idx;
    logic signed [XY_W-1:0] w_x, w_y;
    logic [31:0]            w_idx32;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr, w_rd_addr;
    logic [ENTRY_W-1:0]     w_rd_data;
    t_dp_cmd                w_cmd;
    t_dp_sts                w_sts;
    logic signed [XY_W-1:0] w_y_result;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RST;
            r_desc   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POINTS: r_points <= i_cfg_data[PTS_W-1:0];
                REG_DESC:   r_desc   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Input word fields
    assign w_idx = s_axis_tdata[IN_IDX_LO +: IDX_W];
    assign w_x   = s_axis_tdata[IN_X_LO +: XY_W];
    assign w_y   = s_axis_tdata[IN_Y_LO +: XY_W];

    // Breakpoint load
    assign w_idx32   = 32'(w_idx);
    assign w_wr_addr = w_idx32[AW-1:0];
    assign w_wr_en   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_LOAD)
                       && (w_idx32 < 32'(MAX_POINTS));

    pwli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ({w_y, w_x}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pwli_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_query  (s_axis_tuser == MODE_QUERY),
        .o_in_ready  (s_axis_tready),
        .i_points    (r_points),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    pwli_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_desc     (r_desc),
        .i_query_x  (w_x),
        .i_rd_data  (w_rd_data),
        .o_y_result (w_y_result),
        .o_clamped  (m_axis_tuser)
    );

    assign m_axis_tdata = w_y_result;

endmodule

`default_nettype wire
